### hw/rtl/shape_pair_collision_and_push_assert.svh
`ifndef SHAPE_PAIR_COLLISION_AND_PUSH_ASSERT_SVH
`define SHAPE_PAIR_COLLISION_AND_PUSH_ASSERT_SVH

// Condition must never be seen outside reset.
`define SPCP_ASSERT_NEVER(lbl, cond, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

// Pre on one edge implies post on the next.
`define SPCP_ASSERT_NEXT(lbl, pre, post, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) else $error(msg);

`endif

### hw/rtl/spcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spcp_pkg;

    localparam int CB     = 24;  // coordinate width, raw LSB units
    localparam int TB     = 30;  // segment parameter fraction bits
    localparam int MID_AW = 2;   // front to back queue, log2 depth
    localparam int OUT_AW = 1;   // result queue, log2 depth

    localparam logic [1:0] KIND_CC = 2'd0;  // circle vs circle
    localparam logic [1:0] KIND_CR = 2'd1;  // circle vs rectangle
    localparam logic [1:0] KIND_RR = 2'd2;  // rectangle vs rectangle
    localparam logic [1:0] KIND_CS = 2'd3;  // circle vs segment

    typedef struct packed {
        logic [1:0]           req_type;
        logic signed [CB-1:0] a_x;
        logic signed [CB-1:0] a_y;
        logic [CB-2:0]        a_w;
        logic [CB-2:0]        a_h;
        logic signed [CB-1:0] b_x;
        logic signed [CB-1:0] b_y;
        logic signed [CB-1:0] b_u;
        logic signed [CB-1:0] b_v;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic signed [CB-1:0] push_x;
        logic signed [CB-1:0] push_y;
        logic signed [CB-1:0] near_x;
        logic signed [CB-1:0] near_y;
    } t_res;

    // Classified item: circle centre, radius and target point, or the
    // finished rectangle pair result.
    typedef struct packed {
        logic [1:0]           kind;
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] cy;
        logic signed [CB:0]   rad;
        logic signed [CB:0]   tx;
        logic signed [CB:0]   ty;
        logic                 hit_rr;
        logic signed [CB+1:0] px_rr;
        logic signed [CB+1:0] py_rr;
    } t_mid;

endpackage

`default_nettype wire

### hw/rtl/spcp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

`include "shape_pair_collision_and_push_assert.svh"

module spcp_fifo #(
    parameter int W  = 8,
    parameter int AW = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_full,
    input  logic [W-1:0] i_data,
    output logic         o_empty,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);

    localparam int DEPTH = 1 << AW;

    logic [W-1:0]  r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_data;
    end

    `SPCP_ASSERT_NEVER(a_cnt_bound, r_cnt > (AW+1)'(DEPTH), "queue count above depth")
    `SPCP_ASSERT_NEXT(a_push_fills, w_push, !o_empty, "queue empty after a push")
    `SPCP_ASSERT_NEXT(a_last_pop, w_pop && !w_push && r_cnt == 1, o_empty,
        "queue not empty after last pop")

endmodule

`default_nettype wire

### hw/rtl/spcp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module spcp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  spcp_pkg::t_req   i_req,
    output logic             o_valid,
    output spcp_pkg::t_mid   o_mid,
    input  logic             i_ready
);

    localparam int C  = spcp_pkg::CB;
    localparam int TB = spcp_pkg::TB;
    localparam int LW = 2*C + 2;        // squared length, division remainder
    localparam int MW = C + TB + 2;     // direction times parameter
    localparam int NS = TB + 4;         // products, sums, TB steps, mult, select

    localparam logic [1:0] SEL_START = 2'd0;
    localparam logic [1:0] SEL_END   = 2'd1;
    localparam logic [1:0] SEL_DIV   = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic signed [C-1:0] ax;
        logic signed [C-1:0] ay;
        logic [C-2:0]        aw;
        logic signed [C-1:0] bx;
        logic signed [C-1:0] by;
        logic signed [C-1:0] bu;
        logic signed [C-1:0] bv;
        logic signed [C:0]   ddx;
        logic signed [C:0]   ddy;
        logic signed [C:0]   cnx;
        logic signed [C:0]   cny;
        logic                hit_rr;
        logic signed [C+1:0] px_rr;
        logic signed [C+1:0] py_rr;
        logic [1:0]          sel;
    } t_fcar;

    logic [NS-1:0]          r_v;
    t_fcar                  r_car [0:TB+2];
    logic signed [2*C+1:0]  r_pxx, r_pyy, r_lxx, r_lyy;
    logic [LW-1:0]          r_rem [0:TB];
    logic [TB-1:0]          r_t   [0:TB];
    logic [LW-1:0]          r_l2  [0:TB];
    logic signed [MW-1:0]   r_mx, r_my;
    spcp_pkg::t_mid         r_mid;

    logic                   w_en;
    t_fcar                  w_cara;
    t_fcar                  w_carb;
    logic signed [C:0]      w_ex, w_ey, w_hx, w_hy;
    logic signed [C+1:0]    w_x1, w_x2, w_y1, w_y2, w_xo, w_yo;
    logic signed [2*C+2:0]  w_dot;
    logic [LW-1:0]          w_l2;
    logic [1:0]             w_sel;
    logic [LW:0]            w_r2  [0:TB-1];
    logic                   w_ge  [0:TB-1];
    logic [LW-1:0]          n_rem [1:TB];
    logic [TB-1:0]          n_t   [1:TB];
    spcp_pkg::t_mid         w_mid;
    logic signed [C+1:0]    w_offx, w_offy;
    logic signed [C:0]      w_snx, w_sny;

    // direction times truncated parameter, rounded off by TB bits
    function automatic logic signed [C+1:0] seg_off(input logic signed [MW-1:0] m);
        logic [MW-1:0]       mg;
        logic [MW-1:0]       q;
        logic signed [C+1:0] qs;
        mg = m[MW-1] ? MW'(unsigned'(-m)) : MW'(unsigned'(m));
        q  = (mg + (MW'(1) << (TB-1))) >> TB;
        qs = (C+2)'(q);
        return m[MW-1] ? -qs : qs;
    endfunction

    assign w_en    = !r_v[NS-1] || i_ready;
    assign o_full  = !w_en;
    assign o_valid = r_v[NS-1];
    assign o_mid   = r_mid;

    // stage A: raw differences, products, box clamp, rectangle pair
    always_comb begin
        w_cara.kind = i_req.req_type;
        w_cara.ax   = i_req.a_x;
        w_cara.ay   = i_req.a_y;
        w_cara.aw   = i_req.a_w;
        w_cara.bx   = i_req.b_x;
        w_cara.by   = i_req.b_y;
        w_cara.bu   = i_req.b_u;
        w_cara.bv   = i_req.b_v;
        w_cara.ddx  = (C+1)'(i_req.b_u) - (C+1)'(i_req.b_x);
        w_cara.ddy  = (C+1)'(i_req.b_v) - (C+1)'(i_req.b_y);
        w_ex        = (C+1)'(i_req.a_x) - (C+1)'(i_req.b_x);
        w_ey        = (C+1)'(i_req.a_y) - (C+1)'(i_req.b_y);

        w_hx = (C+1)'(i_req.b_x) + (C+1)'(i_req.b_u);
        w_hy = (C+1)'(i_req.b_y) + (C+1)'(i_req.b_v);
        if (i_req.a_x < i_req.b_x)             w_cara.cnx = (C+1)'(i_req.b_x);
        else if ((C+1)'(i_req.a_x) > w_hx)     w_cara.cnx = w_hx;
        else                                   w_cara.cnx = (C+1)'(i_req.a_x);
        if (i_req.a_y < i_req.b_y)             w_cara.cny = (C+1)'(i_req.b_y);
        else if ((C+1)'(i_req.a_y) > w_hy)     w_cara.cny = w_hy;
        else                                   w_cara.cny = (C+1)'(i_req.a_y);

        w_x1 = (C+2)'(i_req.a_x) + (C+2)'({1'b0, i_req.a_w}) - (C+2)'(i_req.b_x);
        w_x2 = (C+2)'(i_req.b_x) + (C+2)'(i_req.b_u) - (C+2)'(i_req.a_x);
        w_y1 = (C+2)'(i_req.a_y) + (C+2)'({1'b0, i_req.a_h}) - (C+2)'(i_req.b_y);
        w_y2 = (C+2)'(i_req.b_y) + (C+2)'(i_req.b_v) - (C+2)'(i_req.a_y);
        w_cara.hit_rr = (w_x1 > 0) && (w_x2 > 0) && (w_y1 > 0) && (w_y2 > 0);
        w_xo = (w_x1 < w_x2) ? w_x1 : w_x2;
        w_yo = (w_y1 < w_y2) ? w_y1 : w_y2;
        if (w_xo < 0) w_xo = '0;
        if (w_yo < 0) w_yo = '0;
        w_cara.px_rr = (w_xo < w_yo) ? w_xo : '0;
        w_cara.py_rr = (w_xo < w_yo) ? '0 : w_yo;
        w_cara.sel   = SEL_START;
    end

    // stage B: dot product, squared length, segment case
    always_comb begin
        w_dot = (2*C+3)'(r_pxx) + (2*C+3)'(r_pyy);
        w_l2  = LW'(unsigned'(r_lxx)) + LW'(unsigned'(r_lyy));
        if (w_dot <= 0 || w_l2 == '0)            w_sel = SEL_START;
        else if (w_dot >= $signed({1'b0, w_l2})) w_sel = SEL_END;
        else                                     w_sel = SEL_DIV;
        w_carb     = r_car[0];
        w_carb.sel = w_sel;
    end

    // one parameter bit per stage
    always_comb begin
        for (int j = 0; j < TB; j++) begin
            w_r2[j]    = {r_rem[j], 1'b0};
            w_ge[j]    = w_r2[j] >= {1'b0, r_l2[j]};
            n_rem[j+1] = w_ge[j] ? LW'(w_r2[j] - {1'b0, r_l2[j]}) : w_r2[j][LW-1:0];
            n_t[j+1]   = {r_t[j][TB-2:0], w_ge[j]};
        end
    end

    // last stage: pick the target point
    always_comb begin
        w_offx = seg_off(r_mx);
        w_offy = seg_off(r_my);
        w_snx  = (C+1)'((C+2)'(r_car[TB+2].bx) + w_offx);
        w_sny  = (C+1)'((C+2)'(r_car[TB+2].by) + w_offy);

        w_mid.kind   = r_car[TB+2].kind;
        w_mid.cx     = r_car[TB+2].ax;
        w_mid.cy     = r_car[TB+2].ay;
        w_mid.hit_rr = r_car[TB+2].hit_rr;
        w_mid.px_rr  = r_car[TB+2].px_rr;
        w_mid.py_rr  = r_car[TB+2].py_rr;
        w_mid.rad    = (C+1)'({1'b0, r_car[TB+2].aw});
        w_mid.tx     = (C+1)'(r_car[TB+2].bx);
        w_mid.ty     = (C+1)'(r_car[TB+2].by);
        case (r_car[TB+2].kind)
            spcp_pkg::KIND_CC: begin
                w_mid.rad = (C+1)'({1'b0, r_car[TB+2].aw}) + (C+1)'(r_car[TB+2].bu);
            end
            spcp_pkg::KIND_CR: begin
                w_mid.tx = r_car[TB+2].cnx;
                w_mid.ty = r_car[TB+2].cny;
            end
            spcp_pkg::KIND_CS: begin
                if (r_car[TB+2].sel == SEL_END) begin
                    w_mid.tx = (C+1)'(r_car[TB+2].bu);
                    w_mid.ty = (C+1)'(r_car[TB+2].bv);
                end else if (r_car[TB+2].sel == SEL_DIV) begin
                    w_mid.tx = w_snx;
                    w_mid.ty = w_sny;
                end
            end
            default: begin
                w_mid.tx = '0;
                w_mid.ty = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NS-2:0], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_car[0] <= w_cara;
            r_pxx    <= w_cara.ddx * w_ex;
            r_pyy    <= w_cara.ddy * w_ey;
            r_lxx    <= w_cara.ddx * w_cara.ddx;
            r_lyy    <= w_cara.ddy * w_cara.ddy;

            r_car[1]     <= w_carb;
            r_rem[0]     <= w_dot[LW-1:0];
            r_t[0]       <= '0;
            r_l2[0]      <= w_l2;

            for (int j = 1; j <= TB; j++) begin
                r_rem[j] <= n_rem[j];
                r_t[j]   <= n_t[j];
                r_l2[j]  <= r_l2[j-1];
            end
            for (int i = 2; i <= TB+2; i++) begin
                r_car[i] <= r_car[i-1];
            end

            r_mx  <= r_car[TB+1].ddx * $signed({1'b0, r_t[TB]});
            r_my  <= r_car[TB+1].ddy * $signed({1'b0, r_t[TB]});
            r_mid <= w_mid;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/spcp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module spcp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_take,
    input  spcp_pkg::t_mid   i_mid,
    output logic             o_valid,
    output spcp_pkg::t_res   o_res,
    input  logic             i_ready
);

    localparam int C   = spcp_pkg::CB;
    localparam int DW  = C + 2;         // centre minus target
    localparam int SQW = 2 * DW;        // squared distance
    localparam int K   = DW;            // root bits
    localparam int QW  = C + 3;         // radius minus root
    localparam int PW  = DW + QW;       // direction times depth
    localparam int QB  = C + 1;         // quotient bits before saturation
    localparam int NB  = 7 + K + QB;

    localparam logic signed [C-1:0] HI = {1'b0, {(C-1){1'b1}}};
    localparam logic signed [C-1:0] LO = {1'b1, {(C-1){1'b0}}};
    localparam logic [QB:0]         MAGLO = (QB+1)'(1) << (C-1);

    typedef struct packed {
        logic [1:0]           kind;
        logic signed [C:0]    tx;
        logic signed [C:0]    ty;
        logic signed [C:0]    rad;
        logic                 hit_rr;
        logic signed [C+1:0]  px_rr;
        logic signed [C+1:0]  py_rr;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic                 hit;
    } t_bcar;

    typedef struct packed {
        logic [PW-1:0] rem;
        logic [QB-1:0] quo;
        logic          neg;
        logic          ovf;
    } t_lane;

    logic [NB-1:0]           r_v;
    t_bcar                   r_car [0:NB-2];
    logic signed [SQW-1:0]   r_sxx, r_syy;
    logic signed [2*C+1:0]   r_rr;
    logic [SQW-1:0]          r_sx [0:K];
    logic [SQW-1:0]          r_sr [0:K];
    logic signed [QW-1:0]    r_q;
    logic [K-1:0]            r_nq, r_np;
    logic signed [PW-1:0]    r_prx, r_pry;
    t_lane                   r_lx [0:QB];
    t_lane                   r_ly [0:QB];
    logic [K-1:0]            r_dn [0:QB];
    spcp_pkg::t_res          r_res;

    logic                    w_en;
    t_bcar                   w_car0;
    t_bcar                   w_car2;
    logic [SQW-1:0]          w_d2;
    logic                    w_hit;
    logic [SQW-1:0]          w_b  [0:K-1];
    logic [SQW-1:0]          w_t  [0:K-1];
    logic [SQW-1:0]          n_sx [1:K];
    logic [SQW-1:0]          n_sr [1:K];
    logic [K-1:0]            w_n;
    logic signed [QW-1:0]    w_q;
    spcp_pkg::t_res          w_res;

    function automatic t_lane lane_init(input logic signed [PW-1:0] p,
                                        input logic [K-1:0] n);
        t_lane o;
        o.neg = p[PW-1];
        o.rem = p[PW-1] ? PW'(unsigned'(-p)) : PW'(unsigned'(p));
        o.quo = '0;
        o.ovf = o.rem >= (PW'(n) << QB);
        return o;
    endfunction

    function automatic t_lane lane_step(input t_lane l, input logic [K-1:0] n,
                                        input int k);
        logic [PW-1:0] sh;
        t_lane         o;
        sh = PW'(n) << k;
        o  = l;
        if (l.rem >= sh) begin
            o.rem = l.rem - sh;
            o.quo = {l.quo[QB-2:0], 1'b1};
        end else begin
            o.quo = {l.quo[QB-2:0], 1'b0};
        end
        return o;
    endfunction

    // round half away from zero, then saturate
    function automatic logic signed [C-1:0] lane_fin(input t_lane l,
                                                     input logic [K-1:0] n);
        logic              rnd;
        logic [QB:0]       qf;
        logic signed [C-1:0] v;
        rnd = {l.rem, 1'b0} >= (PW+1)'(n);
        qf  = (QB+1)'(l.quo) + (QB+1)'(rnd);
        if (n == '0)                         v = '0;
        else if (!l.neg && (l.ovf || qf > (QB+1)'(HI))) v = HI;
        else if (!l.neg)                     v = C'(qf);
        else if (l.ovf || qf > MAGLO)        v = LO;
        else                                 v = -C'(qf);
        return v;
    endfunction

    function automatic logic signed [C-1:0] sat_c(input logic signed [C+1:0] v);
        logic signed [C-1:0] o;
        if (v > (C+2)'(HI))      o = HI;
        else if (v < (C+2)'(LO)) o = LO;
        else                     o = C'(v);
        return o;
    endfunction

    assign w_en    = !r_v[NB-1] || i_ready;
    assign o_take  = w_en && i_valid;
    assign o_valid = r_v[NB-1];
    assign o_res   = r_res;

    always_comb begin
        w_car0.kind   = i_mid.kind;
        w_car0.tx     = i_mid.tx;
        w_car0.ty     = i_mid.ty;
        w_car0.rad    = i_mid.rad;
        w_car0.hit_rr = i_mid.hit_rr;
        w_car0.px_rr  = i_mid.px_rr;
        w_car0.py_rr  = i_mid.py_rr;
        w_car0.dx     = DW'(i_mid.cx) - DW'(i_mid.tx);
        w_car0.dy     = DW'(i_mid.cy) - DW'(i_mid.ty);
        w_car0.hit    = 1'b0;
    end

    assign w_d2  = SQW'(unsigned'(r_sxx)) + SQW'(unsigned'(r_syy));
    assign w_hit = (r_car[1].rad > 0) && (w_d2 < SQW'(unsigned'(r_rr)));

    always_comb begin
        w_car2     = r_car[1];
        w_car2.hit = w_hit;
    end

    // one root bit per stage
    always_comb begin
        for (int k = 0; k < K; k++) begin
            w_b[k] = SQW'(1) << (SQW - 2 - 2*k);
            w_t[k] = r_sr[k] + w_b[k];
            if (r_sx[k] >= w_t[k]) begin
                n_sx[k+1] = r_sx[k] - w_t[k];
                n_sr[k+1] = (r_sr[k] >> 1) + w_b[k];
            end else begin
                n_sx[k+1] = r_sx[k];
                n_sr[k+1] = r_sr[k] >> 1;
            end
        end
    end

    assign w_n = r_sr[K][K-1:0];
    assign w_q = QW'(r_car[2+K].rad) - QW'($signed({1'b0, w_n}));

    always_comb begin
        w_res.hit    = r_car[NB-2].hit;
        w_res.push_x = lane_fin(r_lx[QB], r_dn[QB]);
        w_res.push_y = lane_fin(r_ly[QB], r_dn[QB]);
        w_res.near_x = '0;
        w_res.near_y = '0;
        case (r_car[NB-2].kind)
            spcp_pkg::KIND_RR: begin
                w_res.hit    = r_car[NB-2].hit_rr;
                w_res.push_x = sat_c(r_car[NB-2].px_rr);
                w_res.push_y = sat_c(r_car[NB-2].py_rr);
            end
            spcp_pkg::KIND_CR, spcp_pkg::KIND_CS: begin
                w_res.near_x = sat_c((C+2)'(r_car[NB-2].tx));
                w_res.near_y = sat_c((C+2)'(r_car[NB-2].ty));
            end
            default: begin
                w_res.near_x = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NB-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_car[0] <= w_car0;
            r_car[1] <= r_car[0];
            r_car[2] <= w_car2;
            for (int i = 3; i <= NB-2; i++) begin
                r_car[i] <= r_car[i-1];
            end

            r_sxx <= r_car[0].dx * r_car[0].dx;
            r_syy <= r_car[0].dy * r_car[0].dy;
            r_rr  <= r_car[0].rad * r_car[0].rad;

            r_sx[0] <= w_d2;
            r_sr[0] <= '0;
            for (int k = 1; k <= K; k++) begin
                r_sx[k] <= n_sx[k];
                r_sr[k] <= n_sr[k];
            end

            r_nq  <= w_n;
            r_q   <= w_q;
            r_np  <= r_nq;
            r_prx <= r_car[3+K].dx * r_q;
            r_pry <= r_car[3+K].dy * r_q;

            r_lx[0] <= lane_init(r_prx, r_np);
            r_ly[0] <= lane_init(r_pry, r_np);
            r_dn[0] <= r_np;
            for (int j = 0; j < QB; j++) begin
                r_lx[j+1] <= lane_step(r_lx[j], r_dn[j], QB - 1 - j);
                r_ly[j+1] <= lane_step(r_ly[j], r_dn[j], QB - 1 - j);
                r_dn[j+1] <= r_dn[j];
            end

            r_res <= w_res;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/shape_pair_collision_and_push.sv
// Throughput: one item per cycle unless a full queue stalls a side, set by
// the fully pipelined front divider, square root and push dividers (one bit
// per stage each).
// Reset: synchronous, active low; clears all valid bits and queue pointers.
`timescale 1ns / 1ps
`default_nettype none

module shape_pair_collision_and_push #(
    parameter int MID_AW = spcp_pkg::MID_AW,
    parameter int OUT_AW = spcp_pkg::OUT_AW
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  spcp_pkg::t_req i_req,
    output logic           empty,
    input  logic           pop,
    output spcp_pkg::t_res o_res
);

    // Front: products, box clamp and rectangle pair in one stage, then the
    // segment parameter by restoring division, one bit per stage, and the
    // rounded point on the segment. Every item passes the same stages, so
    // the front never reorders.
    logic           w_f_valid;
    spcp_pkg::t_mid w_f_mid;

    // Queue between front and back: each side stalls on its own.
    logic           w_m_full;
    logic           w_m_empty;
    spcp_pkg::t_mid w_m_data;

    // Back: distance, integer root, depth times direction and two dividers.
    logic           w_b_take;
    logic           w_b_valid;
    spcp_pkg::t_res w_b_res;

    // Result queue: lets the back hand over while the consumer waits.
    logic           w_o_full;
    logic           w_f_ready;
    logic           w_m_avail;
    logic           w_o_ready;

    assign w_f_ready = !w_m_full;
    assign w_m_avail = !w_m_empty;
    assign w_o_ready = !w_o_full;

    spcp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_req   (i_req),
        .o_valid (w_f_valid),
        .o_mid   (w_f_mid),
        .i_ready (w_f_ready)
    );

    spcp_fifo #(
        .W  ($bits(spcp_pkg::t_mid)),
        .AW (MID_AW)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .o_full  (w_m_full),
        .i_data  (w_f_mid),
        .o_empty (w_m_empty),
        .i_pop   (w_b_take),
        .o_data  (w_m_data)
    );

    spcp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_m_avail),
        .o_take  (w_b_take),
        .i_mid   (w_m_data),
        .o_valid (w_b_valid),
        .o_res   (w_b_res),
        .i_ready (w_o_ready)
    );

    spcp_fifo #(
        .W  ($bits(spcp_pkg::t_res)),
        .AW (OUT_AW)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_b_valid),
        .o_full  (w_o_full),
        .i_data  (w_b_res),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (o_res)
    );

endmodule

`default_nettype wire
